@@ rtl/jsu_pkg.sv @@
// shared types, codes and helper functions for the json string unescape unit
`default_nettype none

package jsu_pkg;

    localparam int unsigned MAX_RES = 6;
    localparam int unsigned RES_W   = $clog2(MAX_RES + 1);
    localparam int unsigned IDX_W   = $clog2(MAX_RES);

    typedef enum logic [2:0] {
        ST_DATA   = 3'd0,
        ST_CLOSED = 3'd1,
        ST_UNTERM = 3'd2,
        ST_BADESC = 3'd3,
        ST_BADHEX = 3'd4,
        ST_TRUNC  = 3'd5
    } t_status;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    localparam logic [15:0] HI_MIN = 16'hD800;
    localparam logic [15:0] HI_MAX = 16'hDBFF;
    localparam logic [15:0] LO_MIN = 16'hDC00;
    localparam logic [15:0] LO_MAX = 16'hDFFF;

    typedef struct packed {
        t_status    status;
        logic [7:0] data;
    } t_res;

    typedef struct packed {
        logic       bad;
        logic [3:0] val;
    } t_hex;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      n;
    } t_utf8;

    function automatic t_hex hex_digit(input logic [7:0] c);
        t_hex h;
        h.bad = 1'b0;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.val = c[3:0] + 4'd9;
        end else begin
            h.bad = 1'b1;
        end
        return h;
    endfunction

    function automatic t_utf8 utf8_encode(input logic [20:0] cp);
        t_utf8 u;
        u.b = '0;
        if (cp < 21'h80) begin
            u.b[0] = cp[7:0];
            u.n    = 3'd1;
        end else if (cp < 21'h800) begin
            u.b[0] = {3'b110, cp[10:6]};
            u.b[1] = {2'b10, cp[5:0]};
            u.n    = 3'd2;
        end else if (cp < 21'h10000) begin
            u.b[0] = {4'b1110, cp[15:12]};
            u.b[1] = {2'b10, cp[11:6]};
            u.b[2] = {2'b10, cp[5:0]};
            u.n    = 3'd3;
        end else begin
            u.b[0] = {5'b11110, cp[20:18]};
            u.b[1] = {2'b10, cp[17:12]};
            u.b[2] = {2'b10, cp[11:6]};
            u.b[3] = {2'b10, cp[5:0]};
            u.n    = 3'd4;
        end
        return u;
    endfunction

endpackage

`default_nettype wire

@@ rtl/json_string_unescape_utf8_unit.sv @@
// json string body decoder: unescapes one byte per item and emits utf-8 result items
// timing: an accepted item is captured in the input register, then decoded from it into the
//   result buffer once that buffer is free; its first result is shown from the result buffer
// throughput: one item per cycle while each item gives at most one result and m_axis_tready
//   is high; else the next item waits in the input register as the buffer drains one per cycle
// reset: synchronous active-low i_rst_n empties both registers and returns to idle
`default_nettype none

module json_string_unescape_utf8_unit
    import jsu_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic [1:0]  s_axis_tuser,   // [0] begin_req, [1] text_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [10:8] status, rest zero
    output logic             m_axis_tlast    // last
);

    typedef enum logic [2:0] {
        M_IDLE, M_STR, M_ESC, M_HEX, M_HI, M_HIESC, M_HIHEX
    } t_mode;

    t_mode             r_mode, n_mode;
    logic [15:0]       r_acc, n_acc;
    logic [15:0]       r_held, n_held;
    logic [2:0]        r_cnt, n_cnt;
    logic              r_bad, n_bad;

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_begin;
    logic              r_in_end;

    t_res              r_buf [MAX_RES];
    logic [RES_W-1:0]  r_num;
    logic [IDX_W-1:0]  r_idx;

    logic              out_last;
    logic              buf_free;
    logic              load_en;
    logic              in_acc;

    // per-byte actions shared by several modes
    t_mode             str_mode, esc_mode;
    logic              str_put, esc_put;
    t_res              str_res, esc_res;

    t_hex              dig;
    logic [15:0]       dig_acc;
    logic [2:0]        dig_cnt;
    logic              dig_bad;

    logic              pre;
    t_res              tail [4];
    logic [2:0]        tail_n;
    t_utf8             enc_held, enc_code, enc_pair;
    logic              code_hi, code_lo;
    logic [20:0]       pair_cp;

    t_res              ent [MAX_RES];
    logic [RES_W-1:0]  ent_n;

    assign out_last      = (RES_W'(r_idx) == r_num - RES_W'(1));
    assign m_axis_tvalid = (r_num != '0);
    assign m_axis_tdata  = {5'd0, r_buf[r_idx]};
    assign m_axis_tlast  = out_last;
    assign buf_free      = (r_num == '0) || (m_axis_tready && out_last);
    assign load_en       = r_in_valid && buf_free;
    assign s_axis_tready = !r_in_valid || buf_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign dig      = hex_digit(r_in_byte);
    assign dig_acc  = {r_acc[11:0], dig.val};
    assign dig_cnt  = r_cnt + 3'd1;
    assign dig_bad  = r_bad | dig.bad;
    assign code_hi  = (dig_acc >= HI_MIN) && (dig_acc <= HI_MAX);
    assign code_lo  = (dig_acc >= LO_MIN) && (dig_acc <= LO_MAX);
    assign pair_cp  = 21'h10000 + {1'b0, r_held[9:0], dig_acc[9:0]};
    assign enc_held = utf8_encode({5'd0, r_held});
    assign enc_code = utf8_encode({5'd0, dig_acc});
    assign enc_pair = utf8_encode(pair_cp);

    always_comb begin
        str_put  = 1'b1;
        str_mode = M_STR;
        str_res  = '{status: ST_DATA, data: r_in_byte};
        if (r_in_byte == CH_QUOTE) begin
            str_mode = M_IDLE;
            str_res  = '{status: ST_CLOSED, data: 8'd0};
        end else if (r_in_byte == CH_BSL) begin
            str_put  = 1'b0;
            str_mode = M_ESC;
        end
    end

    always_comb begin
        esc_put  = 1'b1;
        esc_mode = M_STR;
        esc_res  = '{status: ST_DATA, data: r_in_byte};
        unique case (r_in_byte)
            CH_QUOTE, CH_BSL, CH_SLASH: esc_res.data = r_in_byte;
            CH_B:    esc_res.data = 8'h08;
            CH_F:    esc_res.data = 8'h0C;
            CH_N:    esc_res.data = 8'h0A;
            CH_R:    esc_res.data = 8'h0D;
            CH_T:    esc_res.data = 8'h09;
            CH_U: begin
                esc_put  = 1'b0;
                esc_mode = M_HEX;
            end
            default: begin
                esc_mode = M_IDLE;
                esc_res  = '{status: ST_BADESC, data: 8'd0};
            end
        endcase
    end

    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        n_held = r_held;
        n_cnt  = r_cnt;
        n_bad  = r_bad;
        pre    = 1'b0;
        tail_n = 3'd0;
        for (int k = 0; k < 4; k++) begin
            tail[k] = '{status: ST_DATA, data: 8'd0};
        end
        if (r_in_begin) begin
            n_mode = M_STR;
            n_acc  = '0;
            n_held = '0;
            n_cnt  = '0;
            n_bad  = 1'b0;
        end else if (r_in_end) begin
            n_mode = M_IDLE;
            unique case (r_mode)
                M_STR, M_ESC: begin
                    tail[0] = '{status: ST_UNTERM, data: 8'd0};
                    tail_n  = 3'd1;
                end
                M_HEX: begin
                    tail[0] = '{status: ST_TRUNC, data: 8'd0};
                    tail_n  = 3'd1;
                end
                M_HI, M_HIESC: begin
                    pre     = 1'b1;
                    tail[0] = '{status: ST_UNTERM, data: 8'd0};
                    tail_n  = 3'd1;
                end
                M_HIHEX: begin
                    pre     = 1'b1;
                    tail[0] = '{status: ST_TRUNC, data: 8'd0};
                    tail_n  = 3'd1;
                end
                default: n_mode = M_IDLE;
            endcase
        end else begin
            unique case (r_mode)
                M_STR: begin
                    n_mode  = str_mode;
                    tail[0] = str_res;
                    tail_n  = {2'd0, str_put};
                end
                M_ESC, M_HIESC: begin
                    if (r_mode == M_HIESC) begin
                        pre = (r_in_byte != CH_U);
                    end
                    n_mode  = esc_mode;
                    tail[0] = esc_res;
                    tail_n  = {2'd0, esc_put};
                    if (esc_mode == M_HEX) begin
                        n_mode = (r_mode == M_HIESC) ? M_HIHEX : M_HEX;
                        n_acc  = '0;
                        n_cnt  = '0;
                        n_bad  = 1'b0;
                    end
                end
                M_HI: begin
                    if (r_in_byte == CH_BSL) begin
                        n_mode = M_HIESC;
                    end else begin
                        pre     = 1'b1;
                        n_mode  = str_mode;
                        tail[0] = str_res;
                        tail_n  = {2'd0, str_put};
                    end
                end
                M_HEX, M_HIHEX: begin
                    n_acc = dig_acc;
                    n_cnt = dig_cnt;
                    n_bad = dig_bad;
                    if (dig_cnt == 3'd4) begin
                        if (r_mode == M_HIHEX && !dig_bad && code_lo) begin
                            n_mode = M_STR;
                            for (int k = 0; k < 4; k++) begin
                                tail[k] = '{status: ST_DATA, data: enc_pair.b[k]};
                            end
                            tail_n = enc_pair.n;
                        end else begin
                            pre = (r_mode == M_HIHEX);
                            if (dig_bad) begin
                                n_mode  = M_IDLE;
                                tail[0] = '{status: ST_BADHEX, data: 8'd0};
                                tail_n  = 3'd1;
                            end else if (code_hi) begin
                                n_held = dig_acc;
                                n_mode = M_HI;
                            end else begin
                                n_mode = M_STR;
                                for (int k = 0; k < 4; k++) begin
                                    tail[k] = '{status: ST_DATA, data: enc_code.b[k]};
                                end
                                tail_n = enc_code.n;
                            end
                        end
                    end
                end
                default: n_mode = M_IDLE;
            endcase
        end
    end

    // a held high surrogate always encodes to three bytes ahead of the tail
    always_comb begin
        for (int k = 0; k < MAX_RES; k++) begin
            ent[k] = '{status: ST_DATA, data: 8'd0};
        end
        if (pre) begin
            for (int k = 0; k < 3; k++) begin
                ent[k]     = '{status: ST_DATA, data: enc_held.b[k]};
                ent[k + 3] = tail[k];
            end
            ent_n = RES_W'(tail_n) + RES_W'(3);
        end else begin
            for (int k = 0; k < 4; k++) begin
                ent[k] = tail[k];
            end
            ent_n = RES_W'(tail_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_IDLE;
            r_acc      <= '0;
            r_held     <= '0;
            r_cnt      <= '0;
            r_bad      <= 1'b0;
            r_in_valid <= 1'b0;
            r_num      <= '0;
            r_idx      <= '0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (buf_free) begin
                r_in_valid <= 1'b0;
            end
            if (load_en) begin
                r_mode <= n_mode;
                r_acc  <= n_acc;
                r_held <= n_held;
                r_cnt  <= n_cnt;
                r_bad  <= n_bad;
                r_num  <= ent_n;
                r_idx  <= '0;
            end else if (m_axis_tvalid && m_axis_tready) begin
                if (out_last) begin
                    r_num <= '0;
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte  <= s_axis_tdata;
            r_in_begin <= s_axis_tuser[0];
            r_in_end   <= s_axis_tuser[1];
        end
        if (load_en) begin
            for (int k = 0; k < MAX_RES; k++) begin
                r_buf[k] <= ent[k];
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/jsu_checker.sv @@
// port-level checks for the json string unescape unit, bound to the top level
`default_nettype none

module jsu_checker
    import jsu_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    logic [2:0] st;
    assign st = m_axis_tdata[10:8];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result item changed while stalled");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> st <= ST_TRUNC && m_axis_tdata[15:11] == 5'd0)
        else $error("status out of range");

    a_status_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && st != ST_DATA |-> m_axis_tdata[7:0] == 8'd0)
        else $error("non-data status with nonzero byte");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && st != ST_DATA |-> m_axis_tlast)
        else $error("end of string not on the final result");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with no result pending");

endmodule

bind json_string_unescape_utf8_unit jsu_checker u_jsu_checker (.*);

`default_nettype wire
